// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define BCV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcv check failed");

// Clocked check that also holds during reset.
`define BCV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bcv check failed");

`endif

// ===== rtl/bcv_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the block CRC verifier.
// No dependencies.
package bcv_pkg;

    localparam int unsigned LEN_W = 17;

    localparam logic [31:0]      CRC_POLY         = 32'hEDB8_8320;
    localparam logic [31:0]      CRC_INIT         = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] BLOCK_SIZE_RESET = 17'd16384;
    localparam logic [LEN_W-1:0] MAX_BLOCK_BYTES  = 17'd65536;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        end_of_file;
        logic [31:0] expected_crc;
    } t_in_req;

    typedef struct packed {
        logic [31:0]      block_offset;
        logic [LEN_W-1:0] block_length;
        logic [31:0]      computed_crc;
        logic             mismatch;
        logic             last_block;
    } t_out_req;

    // Reflected CRC-32 update by one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/bcv_in_reg.sv =====
// Input register stage of the block CRC verifier.
// Depends on bcv_pkg for the request type.
module bcv_in_reg
    import bcv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_req,
    input  logic    i_advance,
    output logic    o_valid,
    output t_in_req o_req
);

    logic    r_valid;
    t_in_req r_req;

    // Take a new request whenever the held one is empty or moving on.
    assign o_in_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== rtl/bcv_core.sv =====
// Block state, CRC update and result register of the block CRC verifier.
// Depends on bcv_pkg for types, constants and crc32_byte.
module bcv_core
    import bcv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    input  t_in_req          i_req,
    output logic             o_advance,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req
);

    logic [LEN_W-1:0] r_block_size;
    logic [31:0]      r_crc, n_crc;
    logic [LEN_W-1:0] r_count, n_count;
    logic [31:0]      r_start, n_start;
    logic             r_out_valid, n_out_valid;
    t_out_req         r_out, n_out;

    logic [LEN_W-1:0] eff_size;
    logic [31:0]      crc_upd;
    logic [LEN_W-1:0] count_inc;
    logic             fire;
    logic             emit;

    assign o_advance = !r_out_valid || i_out_ready;
    assign fire      = i_valid && o_advance;

    always_comb begin
        if (r_block_size == '0) begin
            eff_size = LEN_W'(1);
        end else if (r_block_size > MAX_BLOCK_BYTES) begin
            eff_size = MAX_BLOCK_BYTES;
        end else begin
            eff_size = r_block_size;
        end
    end

    assign crc_upd   = crc32_byte(r_crc, i_req.data_byte);
    assign count_inc = r_count + LEN_W'(1);

    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        n_start = r_start;
        n_out   = r_out;
        emit    = 1'b0;
        if (fire) begin
            if (i_req.has_byte) begin
                n_crc   = crc_upd;
                n_count = count_inc;
                if (count_inc >= eff_size) begin
                    emit                = 1'b1;
                    n_out.block_offset  = r_start;
                    n_out.block_length  = count_inc;
                    n_out.computed_crc  = crc_upd ^ CRC_INIT;
                    n_out.mismatch      = (crc_upd ^ CRC_INIT) != i_req.expected_crc;
                    n_out.last_block    = 1'b0;
                    n_crc               = CRC_INIT;
                    n_count             = '0;
                    n_start             = r_start + {{(32-LEN_W){1'b0}}, count_inc};
                end
            end else if (i_req.end_of_file) begin
                emit                = 1'b1;
                n_out.block_offset  = r_start;
                n_out.block_length  = r_count;
                n_out.computed_crc  = r_crc ^ CRC_INIT;
                n_out.mismatch      = (r_crc ^ CRC_INIT) != i_req.expected_crc;
                n_out.last_block    = 1'b1;
                n_crc               = CRC_INIT;
                n_count             = '0;
                n_start             = '0;
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RESET;
            r_crc        <= CRC_INIT;
            r_count      <= '0;
            r_start      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_size <= i_cfg_wdata;
            end
            r_crc       <= n_crc;
            r_count     <= n_count;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== rtl/block_crc32_verifier_top.sv =====
// Top level of the block CRC-32 verifier.
// Depends on bcv_pkg, bcv_in_reg and bcv_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req): one request per byte
//   of the file, or an end-of-file request with has_byte low. A request that
//   carries neither a byte nor end of file is dropped without a result.
//   Output channel (o_out_valid / i_out_ready / o_out_req): one request per
//   closed block with its offset, length, CRC-32, mismatch and last flags.
//   A block closes when it holds block_size bytes or at end of file.
//   Configuration: i_cfg_we / i_cfg_wdata write block_size; write only while
//   the block is idle. Zero acts as one, values above 65536 saturate.
// Throughput and path:
//   One request per cycle sustained while results are taken; a result
//   passes the input register first, then the result register.
//   The per-byte CRC update is a bitwise shift-and-xor loop between them.
// Reset:
//   Synchronous, active low. Block size returns to 16384, the CRC to all
//   ones, count and offset to zero; both registers empty.
// Stall:
//   While a result waits on i_out_ready the input register holds one more
//   request, then o_in_ready drops until the result is taken.
module block_crc32_verifier_top
    import bcv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    // Handoff between the input register and the block logic.
    logic    stage_valid;
    t_in_req stage_req;
    logic    stage_advance;

    // Register the accepted request and hold it until the block logic advances.
    bcv_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_advance  (stage_advance),
        .o_valid    (stage_valid),
        .o_req      (stage_req)
    );

    // Advance the CRC and block counters, register any closed block.
    bcv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (stage_valid),
        .i_req       (stage_req),
        .o_advance   (stage_advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/bcv_checker.sv =====
// Port-level checks for the block CRC verifier, bound to the top level.
// Depends on bcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcv_checker
    import bcv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_req         o_out_req
);

    logic out_stall;
    logic out_full;
    logic out_empty;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_full  = o_out_valid && !o_out_req.last_block;
    assign out_empty = o_out_valid && (o_out_req.block_length == '0);

    `BCV_ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_out_valid)
    `BCV_ASSERT(a_out_held, i_clk, i_rst_n, out_stall |=> o_out_valid && $stable(o_out_req))
    `BCV_ASSERT(a_len_range, i_clk, i_rst_n, o_out_valid |-> o_out_req.block_length <= MAX_BLOCK_BYTES)
    `BCV_ASSERT(a_full_not_empty, i_clk, i_rst_n, out_full |-> o_out_req.block_length != '0)
    `BCV_ASSERT(a_empty_crc_zero, i_clk, i_rst_n, out_empty |-> o_out_req.computed_crc == '0)

endmodule

bind block_crc32_verifier_top bcv_checker u_bcv_checker (.*);
